[hdl/gf2i_pkg.sv]
package gf2i_pkg;

    // Widths fixed by the row and result fields.
    localparam int ROW_W     = 32;
    localparam int ROW_IDX_W = $clog2(ROW_W);
    localparam int CFG_W     = 6;
    localparam int NUM_W     = 5;

    // Largest matrix that the row stores hold.
    localparam int MAX_SIZE = 32;
    localparam int ROW_CAP  = (MAX_SIZE < ROW_W) ? MAX_SIZE : ROW_W;
    localparam int ADDR_W   = (ROW_CAP > 1) ? $clog2(ROW_CAP) : 1;
    localparam int CNT_W    = $clog2(ROW_CAP + 1);

    // Result of the shared row unit for one target row.
    typedef struct packed {
        logic              hit;
        logic [ROW_W-1:0]  work_x;
        logic [ROW_W-1:0]  ident_x;
    } t_alu_res;

    // Size in use: zero acts as one, anything above the capacity acts as the capacity.
    function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] cfg);
        logic [CNT_W-1:0] n;
        if (cfg == '0) begin
            n = CNT_W'(1);
        end else if (int'(cfg) > ROW_CAP) begin
            n = CNT_W'(ROW_CAP);
        end else begin
            n = CNT_W'(cfg);
        end
        return n;
    endfunction

    // Ones in the columns below the size.
    function automatic logic [ROW_W-1:0] size_mask(input logic [CNT_W-1:0] n);
        logic [ROW_W-1:0] m;
        for (int j = 0; j < ROW_W; j++) begin
            m[j] = (j < int'(n));
        end
        return m;
    endfunction

endpackage

[hdl/gf2i_row_alu.sv]
module gf2i_row_alu (
    input  logic [gf2i_pkg::ROW_W-1:0]  i_piv_work,
    input  logic [gf2i_pkg::ROW_W-1:0]  i_piv_ident,
    input  logic [gf2i_pkg::ROW_W-1:0]  i_tgt_work,
    input  logic [gf2i_pkg::ROW_W-1:0]  i_tgt_ident,
    input  logic [gf2i_pkg::ADDR_W-1:0] i_col,
    output gf2i_pkg::t_alu_res          o_res
);

    logic [gf2i_pkg::ROW_IDX_W-1:0] col_idx;

    // Test the target row at the pivot column and form the eliminated rows.
    always_comb begin
        col_idx       = gf2i_pkg::ROW_IDX_W'(i_col);
        o_res.hit     = i_tgt_work[col_idx];
        o_res.work_x  = i_tgt_work ^ i_piv_work;
        o_res.ident_x = i_tgt_ident ^ i_piv_ident;
    end

endmodule

[hdl/gf2_matrix_inverse.sv]
// Channel   | Direction | Signals                                        | Beat
// ----------+-----------+------------------------------------------------+-------------------------
// row in    | in        | start, busy, i_row_bits                        | start high, busy low
// result    | out       | o_result_valid, o_inverse_row, o_row_number,   | one-cycle strobe
//           |           | o_invertible, o_last_result                    |
// config    | in        | i_cfg_valid, o_cfg_ready, i_cfg_data           | valid and ready high
//
// Rows load one per cycle while busy is low; after the n-th row the block is busy while it
// eliminates and emits. All row traffic goes through the single read port of the row stores:
// each pivot column reads the pivot row, searches the rows below and swaps if its bit is
// clear, then reads every row and rewrites those with the bit set. Results come out through
// alternating read and output states and cannot be stalled. Synchronous active-low reset
// sets the size to 32 and empties the load count; the row stores need no reset.
module gf2_matrix_inverse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [gf2i_pkg::ROW_W-1:0]    i_row_bits,
    output logic                          o_result_valid,
    output logic [gf2i_pkg::ROW_W-1:0]    o_inverse_row,
    output logic [gf2i_pkg::NUM_W-1:0]    o_row_number,
    output logic                          o_invertible,
    output logic                          o_last_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gf2i_pkg::CFG_W-1:0]    i_cfg_data
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_PIV_RD,
        S_PIV_CK,
        S_SRCH_RD,
        S_SRCH_CK,
        S_SWAP_P,
        S_EL_RD,
        S_EL_WR,
        S_OUT_RD,
        S_OUT_WR
    } t_state;

    t_state                          r_state;
    logic [gf2i_pkg::ADDR_W-1:0]     r_last;
    logic [gf2i_pkg::ROW_W-1:0]      r_mask;
    logic [gf2i_pkg::ADDR_W-1:0]     r_load_cnt;
    logic [gf2i_pkg::ADDR_W-1:0]     r_col;
    logic [gf2i_pkg::ADDR_W-1:0]     r_row;
    logic [gf2i_pkg::ROW_W-1:0]      r_piv_w;
    logic [gf2i_pkg::ROW_W-1:0]      r_piv_i;
    logic [gf2i_pkg::ROW_W-1:0]      r_swp_w;
    logic [gf2i_pkg::ROW_W-1:0]      r_swp_i;
    logic [gf2i_pkg::ROW_W-1:0]      r_rd_w;
    logic [gf2i_pkg::ROW_W-1:0]      r_rd_i;
    logic                            r_out_valid;
    logic [gf2i_pkg::ROW_W-1:0]      r_out_row;
    logic [gf2i_pkg::NUM_W-1:0]      r_out_num;
    logic                            r_out_inv;
    logic                            r_out_last;

    // Work and identity row stores.
    logic [gf2i_pkg::ROW_W-1:0]      mem_w [gf2i_pkg::ROW_CAP];
    logic [gf2i_pkg::ROW_W-1:0]      mem_i [gf2i_pkg::ROW_CAP];

    logic                            we;
    logic [gf2i_pkg::ADDR_W-1:0]     wa;
    logic [gf2i_pkg::ROW_W-1:0]      wd_w;
    logic [gf2i_pkg::ROW_W-1:0]      wd_i;
    logic [gf2i_pkg::ADDR_W-1:0]     rd_addr;
    logic                            row_acc;
    logic                            cfg_acc;
    logic [gf2i_pkg::CNT_W-1:0]      n_size;
    gf2i_pkg::t_alu_res              alu;

    assign busy        = (r_state != S_LOAD);
    assign o_cfg_ready = !busy;
    assign row_acc     = start && !busy;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign n_size      = gf2i_pkg::eff_size(i_cfg_data);

    assign o_result_valid = r_out_valid;
    assign o_inverse_row  = r_out_row;
    assign o_row_number   = r_out_num;
    assign o_invertible   = r_out_inv;
    assign o_last_result  = r_out_last;

    // Shared row unit: pivot test and row XOR against the row just read.
    gf2i_row_alu u_alu (
        .i_piv_work  (r_piv_w),
        .i_piv_ident (r_piv_i),
        .i_tgt_work  (r_rd_w),
        .i_tgt_ident (r_rd_i),
        .i_col       (r_col),
        .o_res       (alu)
    );

    // Store write and read address selection.
    always_comb begin
        we      = 1'b0;
        wa      = r_row;
        wd_w    = r_rd_w;
        wd_i    = r_rd_i;
        rd_addr = r_row;
        unique case (r_state)
            S_LOAD: begin
                we   = row_acc;
                wa   = r_load_cnt;
                wd_w = i_row_bits & r_mask;
                wd_i = gf2i_pkg::ROW_W'(1) << r_load_cnt;
            end
            S_PIV_RD: begin
                rd_addr = r_col;
            end
            S_SRCH_CK: begin
                // The found row moves up into the pivot place.
                we = alu.hit;
                wa = r_col;
            end
            S_SWAP_P: begin
                we   = 1'b1;
                wa   = r_row;
                wd_w = r_swp_w;
                wd_i = r_swp_i;
            end
            S_EL_WR: begin
                we   = alu.hit && (r_row != r_col);
                wa   = r_row;
                wd_w = alu.work_x;
                wd_i = alu.ident_x;
            end
            default: begin
            end
        endcase
    end

    // Row stores with registered read data.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_w[wa] <= wd_w;
            mem_i[wa] <= wd_i;
        end
        r_rd_w <= mem_w[rd_addr];
        r_rd_i <= mem_i[rd_addr];
    end

    // Sequencer: load, pivot search and swap, elimination, result output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_last      <= gf2i_pkg::ADDR_W'(gf2i_pkg::eff_size(gf2i_pkg::CFG_W'(32)) - 1'b1);
            r_mask      <= gf2i_pkg::size_mask(gf2i_pkg::eff_size(gf2i_pkg::CFG_W'(32)));
            r_load_cnt  <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (row_acc) begin
                        if (r_load_cnt == r_last) begin
                            r_load_cnt <= '0;
                            r_col      <= '0;
                            r_state    <= S_PIV_RD;
                        end else begin
                            r_load_cnt <= r_load_cnt + 1'b1;
                        end
                    end
                    if (cfg_acc) begin
                        r_last     <= gf2i_pkg::ADDR_W'(n_size - 1'b1);
                        r_mask     <= gf2i_pkg::size_mask(n_size);
                        r_load_cnt <= '0;
                    end
                end
                S_PIV_RD: begin
                    r_state <= S_PIV_CK;
                end
                S_PIV_CK: begin
                    r_piv_w <= r_rd_w;
                    r_piv_i <= r_rd_i;
                    if (alu.hit) begin
                        r_row   <= '0;
                        r_state <= S_EL_RD;
                    end else if (r_col == r_last) begin
                        r_out_valid <= 1'b1;
                        r_out_row   <= '0;
                        r_out_num   <= '0;
                        r_out_inv   <= 1'b0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_LOAD;
                    end else begin
                        r_row   <= r_col + 1'b1;
                        r_state <= S_SRCH_RD;
                    end
                end
                S_SRCH_RD: begin
                    r_state <= S_SRCH_CK;
                end
                S_SRCH_CK: begin
                    if (alu.hit) begin
                        // Old pivot row goes down to the found place next cycle.
                        r_swp_w <= r_piv_w;
                        r_swp_i <= r_piv_i;
                        r_piv_w <= r_rd_w;
                        r_piv_i <= r_rd_i;
                        r_state <= S_SWAP_P;
                    end else if (r_row == r_last) begin
                        r_out_valid <= 1'b1;
                        r_out_row   <= '0;
                        r_out_num   <= '0;
                        r_out_inv   <= 1'b0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_LOAD;
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_state <= S_SRCH_RD;
                    end
                end
                S_SWAP_P: begin
                    r_row   <= '0;
                    r_state <= S_EL_RD;
                end
                S_EL_RD: begin
                    r_state <= S_EL_WR;
                end
                S_EL_WR: begin
                    if (r_row == r_last) begin
                        r_row <= '0;
                        if (r_col == r_last) begin
                            r_state <= S_OUT_RD;
                        end else begin
                            r_col   <= r_col + 1'b1;
                            r_state <= S_PIV_RD;
                        end
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_state <= S_EL_RD;
                    end
                end
                S_OUT_RD: begin
                    r_state <= S_OUT_WR;
                end
                S_OUT_WR: begin
                    r_out_valid <= 1'b1;
                    r_out_row   <= r_rd_i & r_mask;
                    r_out_num   <= gf2i_pkg::NUM_W'(r_row);
                    r_out_inv   <= 1'b1;
                    r_out_last  <= (r_row == r_last);
                    if (r_row == r_last) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_state <= S_OUT_RD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

[sim/gf2_matrix_inverse_tb.sv]
`timescale 1ns / 1ps

module gf2_matrix_inverse_tb;

    localparam int RW = gf2i_pkg::ROW_W;
    localparam int NW = gf2i_pkg::NUM_W;
    localparam int CW = gf2i_pkg::CFG_W;

    localparam int ROW_ITEMS    = 220;
    localparam int SETTLE       = 16;
    localparam int DRAIN_CYCLES = 64;
    localparam int STALL_LIMIT  = 25000;

    typedef enum logic {LOAD_ROW, WRITE_SIZE} t_beat_kind;
    typedef enum logic [1:0] {MAT_INVERTIBLE, MAT_SINGULAR, MAT_NOISE} t_matrix_style;

    typedef struct {
        t_beat_kind    kind;
        logic [RW-1:0] data;
        int            gap;
    } t_stim_beat;

    typedef struct packed {
        logic [RW-1:0] inverse_row;
        logic [NW-1:0] row_number;
        logic          invertible;
        logic          last_result;
    } t_inv_result;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          start       = 1'b0;
    logic          busy;
    logic [RW-1:0] i_row_bits  = '0;
    logic          o_result_valid;
    logic [RW-1:0] o_inverse_row;
    logic [NW-1:0] o_row_number;
    logic          o_invertible;
    logic          o_last_result;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [CW-1:0] i_cfg_data  = '0;

    gf2_matrix_inverse dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_row_bits    (i_row_bits),
        .o_result_valid(o_result_valid),
        .o_inverse_row (o_inverse_row),
        .o_row_number  (o_row_number),
        .o_invertible  (o_invertible),
        .o_last_result (o_last_result),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Beats waiting to be driven and inverse rows waiting to come out.
    t_stim_beat  pend_q[$];
    t_inv_result inverse_q[$];

    // Handshake bookkeeping shared by driver and monitor.
    t_stim_beat cur_beat;
    logic       have_next  = 1'b0;
    logic       in_flight  = 1'b0;
    logic       row_taken  = 1'b0;
    logic       size_taken = 1'b0;
    int         quiet_cycles = 0;
    int         stall_cycles = 0;
    int         mismatches   = 0;

    // Predictor state: configured size, rows loaded so far and the two row stores.
    logic [CW-1:0] size_reg  = CW'(32);
    int            rows_held = 0;
    logic [RW-1:0] mat_rows [32];
    logic [RW-1:0] inv_rows [32];

    // Stimulus planning state.
    int plan_n       = 32;
    int rows_planned = 0;

    // Zero acts as one; anything above 32 acts as 32.
    function automatic int active_size(input logic [CW-1:0] raw);
        int n;
        n = int'(raw);
        if (n == 0) n = 1;
        if (n > 32) n = 32;
        return n;
    endfunction

    function automatic logic [RW-1:0] column_mask(input int n);
        return (n >= RW) ? '1 : ((RW'(1) << n) - RW'(1));
    endfunction

    // Load one row; on the last row of a matrix, invert it and queue the inverse rows or a singular result.
    task automatic absorb_row(input logic [RW-1:0] bits);
        int            n;
        int            p;
        logic [RW-1:0] mask;
        logic [RW-1:0] t;
        logic          full_rank;
        t_inv_result   res;
        n    = active_size(size_reg);
        mask = column_mask(n);
        if (rows_held >= n) rows_held = 0;
        mat_rows[rows_held] = bits & mask;
        rows_held++;
        if (rows_held < n) return;
        rows_held = 0;

        for (int i = 0; i < n; i++) inv_rows[i] = RW'(1) << i;
        full_rank = 1'b1;
        for (int c = 0; c < n && full_rank; c++) begin
            // Bring a row with a one in this column up to the pivot position.
            if (!mat_rows[c][c]) begin
                p = n;
                for (int i = c + 1; i < n && p == n; i++) begin
                    if (mat_rows[i][c]) p = i;
                end
                if (p == n) begin
                    full_rank = 1'b0;
                end else begin
                    t = mat_rows[c]; mat_rows[c] = mat_rows[p]; mat_rows[p] = t;
                    t = inv_rows[c]; inv_rows[c] = inv_rows[p]; inv_rows[p] = t;
                end
            end
            // Clear the column in every other row.
            if (full_rank) begin
                for (int i = 0; i < n; i++) begin
                    if (i != c && mat_rows[i][c]) begin
                        mat_rows[i] ^= mat_rows[c];
                        inv_rows[i] ^= inv_rows[c];
                    end
                end
            end
        end

        if (!full_rank) begin
            res = '{inverse_row: '0, row_number: '0, invertible: 1'b0, last_result: 1'b1};
            inverse_q.push_back(res);
        end else begin
            for (int k = 0; k < n; k++) begin
                res.inverse_row = inv_rows[k] & mask;
                res.row_number  = NW'(k);
                res.invertible  = 1'b1;
                res.last_result = (k == n - 1);
                inverse_q.push_back(res);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [RW-1:0] want,
                               input logic [RW-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Drive row and size beats at the falling edge; each signal gets one assignment.
    always @(negedge i_clk) begin : beat_driver
        logic drv_start;
        logic drv_cfg;
        drv_start = start;
        drv_cfg   = i_cfg_valid;
        if (row_taken) begin
            drv_start = 1'b0;
            in_flight = 1'b0;
        end
        if (size_taken) begin
            drv_cfg   = 1'b0;
            in_flight = 1'b0;
        end
        row_taken  = 1'b0;
        size_taken = 1'b0;
        if (i_rst_n && !in_flight) begin
            if (!have_next && pend_q.size() != 0) begin
                cur_beat  = pend_q.pop_front();
                have_next = 1'b1;
            end
            if (have_next) begin
                if (cur_beat.gap > 0) begin
                    cur_beat.gap--;
                end else if (cur_beat.kind == LOAD_ROW) begin
                    drv_start  = 1'b1;
                    i_row_bits <= cur_beat.data;
                    in_flight  = 1'b1;
                    have_next  = 1'b0;
                end else if (inverse_q.size() == 0 && quiet_cycles >= SETTLE && !busy) begin
                    // Size writes only go out once the block has gone quiet.
                    drv_cfg    = 1'b1;
                    i_cfg_data <= cur_beat.data[CW-1:0];
                    in_flight  = 1'b1;
                    have_next  = 1'b0;
                end
            end
        end
        start       <= drv_start;
        i_cfg_valid <= drv_cfg;
    end

    // Sample handshakes and results at the rising edge, and watch for a hang.
    always @(posedge i_clk) begin : result_monitor
        t_inv_result want;
        logic        progress;
        progress = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                absorb_row(i_row_bits);
                row_taken = 1'b1;
                progress  = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                size_reg   = i_cfg_data;
                rows_held  = 0;
                size_taken = 1'b1;
                progress   = 1'b1;
            end
            if (o_result_valid) begin
                progress = 1'b1;
                if (inverse_q.size() == 0) begin
                    $error("unexpected result: row_number %0d inverse_row 0x%0h",
                           o_row_number, o_inverse_row);
                    mismatches++;
                end else begin
                    want = inverse_q.pop_front();
                    check_field("inverse_row", want.inverse_row, o_inverse_row);
                    check_field("row_number", RW'(want.row_number), RW'(o_row_number));
                    check_field("invertible", RW'(want.invertible), RW'(o_invertible));
                    check_field("last_result", RW'(want.last_result), RW'(o_last_result));
                end
            end
            if (o_result_valid || row_taken || inverse_q.size() != 0) begin
                quiet_cycles = 0;
            end else if (quiet_cycles < SETTLE * 4) begin
                quiet_cycles++;
            end
        end
        stall_cycles = progress ? 0 : stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CW-1:0] pick_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return CW'($urandom_range(1, 4));
        if (pick < 80) return CW'($urandom_range(5, 12));
        if (pick < 88) return '0;
        if (pick < 94) return CW'(32);
        return CW'($urandom_range(33, 63));
    endfunction

    task automatic add_row(input logic [RW-1:0] bits, input int gap);
        t_stim_beat b;
        b = '{kind: LOAD_ROW, data: bits, gap: gap};
        pend_q.push_back(b);
        rows_planned++;
    endtask

    task automatic add_size(input logic [CW-1:0] raw);
        t_stim_beat b;
        b = '{kind: WRITE_SIZE, data: RW'(raw), gap: idle_gap()};
        pend_q.push_back(b);
        plan_n = active_size(raw);
    endtask

    // One whole matrix at the planned size; columns above the size get random junk.
    task automatic add_matrix(input t_matrix_style style, input logic calm);
        logic [RW-1:0] rows [32];
        logic [RW-1:0] mask;
        int            a;
        int            b;
        logic [RW-1:0] t;
        mask = column_mask(plan_n);
        for (int i = 0; i < plan_n; i++) rows[i] = RW'(1) << i;
        // Random row operations keep the matrix at full rank.
        repeat (plan_n * 3) begin
            a = $urandom_range(0, plan_n - 1);
            b = $urandom_range(0, plan_n - 1);
            if (a != b) begin
                if ($urandom_range(0, 3) == 0) begin
                    t = rows[a]; rows[a] = rows[b]; rows[b] = t;
                end else begin
                    rows[a] ^= rows[b];
                end
            end
        end
        if (style == MAT_SINGULAR) begin
            a = $urandom_range(0, plan_n - 1);
            b = $urandom_range(0, plan_n - 1);
            rows[a] = (a != b && $urandom_range(0, 1) == 1) ? rows[b] : '0;
        end else if (style == MAT_NOISE) begin
            for (int i = 0; i < plan_n; i++) rows[i] = $urandom;
        end
        for (int i = 0; i < plan_n; i++) begin
            add_row(rows[i] | ($urandom & ~mask), calm ? 0 : idle_gap());
        end
    endtask

    initial begin : stimulus
        int            pick;
        int            part;
        t_matrix_style style;

        // Default size is 32: two rows give nothing, and the size write discards them.
        add_row(32'hFFFF_FFFF, 0);
        add_row(32'h8000_0000, 0);
        add_size('0);
        // Size zero acts as one: a set low bit inverts, a clear one is singular.
        add_row(32'hFFFF_FFFF, 0);
        add_row(32'hFFFF_FFFE, 1);
        // Two by two: a pivot swap, then two equal rows.
        add_size(CW'(2));
        add_row(32'h0000_0002, 0);
        add_row(32'h0000_0001, 0);
        add_row(32'h0000_0003, 2);
        add_row(32'h0000_0003, 0);
        // A partly loaded matrix is dropped by the next size write.
        add_row(32'h0000_0001, 0);
        add_size(CW'(3));
        // The pivot test fails on the last column.
        add_row(32'h0000_0001, 0);
        add_row(32'h0000_0006, 0);
        add_row(32'h0000_0006, 0);
        // Two swaps in a row.
        add_row(32'h0000_0004, 0);
        add_row(32'h0000_0001, 0);
        add_row(32'h0000_0002, 0);

        // Random part, opened by the top size code at full width.
        add_size(CW'(63));
        add_matrix(MAT_INVERTIBLE, 1'b0);
        while (rows_planned < ROW_ITEMS) begin
            if ($urandom_range(0, 2) == 0) add_size(pick_size());
            pick = $urandom_range(0, 99);
            if (pick < 8 && plan_n > 1) begin
                part = $urandom_range(1, plan_n - 1);
                repeat (part) add_row($urandom, idle_gap());
                add_size(pick_size());
            end else begin
                style = (pick < 60) ? MAT_INVERTIBLE : (pick < 85) ? MAT_SINGULAR : MAT_NOISE;
                add_matrix(style, $urandom_range(0, 3) == 0);
            end
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || have_next || in_flight) @(posedge i_clk);
        while (inverse_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/gf2i_pkg.sv
hdl/gf2i_row_alu.sv
hdl/gf2_matrix_inverse.sv
sim/gf2_matrix_inverse_tb.sv
